// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i outside reset.
`define GEBW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a signal holds while its channel is stalled.
`define GEBW_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  `GEBW_ASSERT(lbl, (vld && !rdy) |=> $stable(sig), msg)

`endif

// ----- rtl/core/gebw_pkg.sv -----
package gebw_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_DIM     = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);

  localparam int CORNER_W = $clog2(MAX_DIM + 1) + 1;
  localparam int POS_W    = CORNER_W + 2;
  localparam int DIFF_W   = POS_W + 1;
  localparam int HUND_W   = DIFF_W + 7;
  localparam int PROD_W   = DIFF_W + HUND_W;
  localparam int A_W      = PROD_W + 1;
  localparam int CMP_W    = A_W + HUND_W;

  localparam int COORD_W = 32;
  localparam int CW_W    = 31;
  localparam int USED_W  = 7;
  localparam int D_W     = 33;
  localparam int NUM_W   = 34;
  localparam int DEN_W   = 32;
  localparam int SNAP_W  = 36;
  localparam int BUMP_W  = CORNER_W + 32;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam int FLAG_W = 4;
  localparam logic [FLAG_W-1:0] FLAGS_OPEN = 4'hF;
  localparam logic [FLAG_W-1:0] FLAG_UP    = 4'b0001;
  localparam logic [FLAG_W-1:0] FLAG_DOWN  = 4'b0010;
  localparam logic [FLAG_W-1:0] FLAG_LEFT  = 4'b0100;
  localparam logic [FLAG_W-1:0] FLAG_RIGHT = 4'b1000;

  localparam int EDGE_W = 8;
  localparam logic [EDGE_W-1:0] WALK_LIMIT = 8'd255;

  localparam int OP_W  = 2;
  localparam int QRY_W = 6;
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USED_COLUMNS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USED_ROWS    = 3'd4;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [FLAG_W-1:0] wdata;
  } mem_req_t;

  // A zero distance counts as one hundredth, all others are scaled by 100.
  function automatic logic signed [HUND_W-1:0] hund(input logic signed [DIFF_W-1:0] v);
    return (v == '0) ? HUND_W'(1) : HUND_W'(v) * HUND_W'(100);
  endfunction

endpackage

// ----- rtl/core/gebw_if.sv -----
interface gebw_in_if import gebw_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            opcode;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic [QRY_W-1:0]           query_row;
  logic [QRY_W-1:0]           query_col;
  modport source (output valid, opcode, point_x, point_y, query_row, query_col, input ready);
  modport sink (input valid, opcode, point_x, point_y, query_row, query_col, output ready);
endinterface

interface gebw_out_if import gebw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FLAG_W-1:0] cell_flags;
  logic [EDGE_W-1:0] edges_walked;
  modport source (output valid, cell_flags, edges_walked, input ready);
  modport sink (input valid, cell_flags, edges_walked, output ready);
endinterface

interface gebw_cfg_if import gebw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/grid_edge_barrier_walker.sv -----
// Flow: a cell read passes the flag memory read, S_RDQ and S_FIN; a start point runs two
// 34-step divides. A next point runs the same divides, then walks at most 255 grid edges,
// each through S_WCHK, S_WM1, S_WM2, S_WDEC, S_WR1, S_WW1, S_WR2 and S_WW2.
// Throughput: one item at a time, set by the shared divider and the flag memory with one
// read and one write port. Reset: asynchronous, active low; all 4096 entries are then
// swept open, during which no item is taken. Configuration writes are taken at any time.
module grid_edge_barrier_walker import gebw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  gebw_in_if.sink    in_i,
  gebw_out_if.source out_o,
  gebw_cfg_if.sink   cfg_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDQ   = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_SNAP  = 4'd4;
  localparam logic [3:0] S_WINIT = 4'd5;
  localparam logic [3:0] S_WCHK  = 4'd6;
  localparam logic [3:0] S_WM1   = 4'd7;
  localparam logic [3:0] S_WM2   = 4'd8;
  localparam logic [3:0] S_WDEC  = 4'd9;
  localparam logic [3:0] S_WR1   = 4'd10;
  localparam logic [3:0] S_WW1   = 4'd11;
  localparam logic [3:0] S_WR2   = 4'd12;
  localparam logic [3:0] S_WW2   = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state_q;

  logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
  logic [CW_W-1:0]           cell_width_q;
  logic [USED_W-1:0]         used_columns_q, used_rows_q;

  logic [OP_W-1:0]           op_q;
  logic signed [COORD_W-1:0] px_q, py_q;
  logic                      axis_q;
  logic signed [D_W-1:0]     d_q;
  logic signed [BUMP_W-1:0]  prod_q;

  logic signed [CORNER_W-1:0] corner_col_q, corner_row_q, next_col_q, next_row_q;
  logic signed [POS_W-1:0]    c_q, r_q, tc_q, tr_q;
  logic signed [DIFF_W-1:0]   dy_q;
  logic                       ci_neg_q, ri_neg_q;
  logic signed [HUND_W-1:0]   dg_q, dcol_q, drow_q;
  logic signed [PROD_W-1:0]   p1_q, p2_q, p3_q, p4_q;
  logic [CMP_W-1:0]           m1_q, m2_q;
  logic [EDGE_W-1:0]          n_q;

  logic [ADDR_W-1:0] addr1_q, addr2_q;
  logic              ok1_q, ok2_q;
  logic [FLAG_W-1:0] mask1_q, mask2_q;
  logic              q_oob_q;

  logic              out_valid_q;
  logic [FLAG_W-1:0] res_flags_q, out_flags_q;
  logic [EDGE_W-1:0] res_edges_q, out_edges_q;

  mem_req_t          mem_req;
  logic [FLAG_W-1:0] mem_rdata;
  logic              store_busy;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic [DEN_W-1:0]  div_den;

  logic              in_acc;
  logic [ADDR_W-1:0] q_addr;
  logic [CW_W-1:0]   w_eff;
  logic signed [CORNER_W-1:0] lim_c, lim_r;
  logic signed [POS_W-1:0]    nc_pos, nr_pos;

  logic signed [COORD_W-1:0]  pt_sel, org_sel;
  logic signed [D_W-1:0]      d_new;
  logic [D_W-1:0]             a_mag;
  logic signed [CORNER_W-1:0] prev_sel;

  logic signed [SNAP_W-1:0]   n_val;
  logic signed [CORNER_W-1:0] snapped;

  logic signed [A_W-1:0]    a_val, b_val;
  logic [A_W-1:0]           a_abs, b_abs;
  logic [HUND_W-1:0]        dcol_abs, drow_abs;

  logic                     col_move;
  logic signed [POS_W-1:0]  mc, mr, row1, col1, row2, col2;

  function automatic logic in_grid(input logic signed [POS_W-1:0] row,
                                   input logic signed [POS_W-1:0] col,
                                   input logic signed [CORNER_W-1:0] lr,
                                   input logic signed [CORNER_W-1:0] lc);
    return (row >= 0) && (col >= 0) && (row < POS_W'(lr)) && (col < POS_W'(lc));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [POS_W-1:0] row,
                                                  input logic signed [POS_W-1:0] col);
    return ADDR_W'(row[ROW_W-1:0]) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col[COL_W-1:0]);
  endfunction

  assign in_i.ready  = (state_q == S_IDLE) && !store_busy;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign q_addr = ADDR_W'(in_i.query_row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(in_i.query_col);
  assign w_eff  = (cell_width_q == '0) ? CW_W'(1) : cell_width_q;
  assign lim_c  = (int'(used_columns_q) > MAX_COLUMNS) ? CORNER_W'(MAX_COLUMNS)
                                                       : CORNER_W'(used_columns_q);
  assign lim_r  = (int'(used_rows_q) > MAX_ROWS) ? CORNER_W'(MAX_ROWS)
                                                 : CORNER_W'(used_rows_q);
  assign nc_pos = POS_W'(next_col_q);
  assign nr_pos = POS_W'(next_row_q);

  // Snap setup: magnitude of the offset, rounding numerator and the bump product.
  assign pt_sel   = axis_q ? py_q : px_q;
  assign org_sel  = axis_q ? origin_y_q : origin_x_q;
  assign d_new    = D_W'(pt_sel) - D_W'(org_sel);
  assign a_mag    = d_new[D_W-1] ? D_W'(-d_new) : D_W'(d_new);
  assign prev_sel = (op_q != OP_NEXT) ? '0 : (axis_q ? corner_row_q : corner_col_q);
  assign div_num  = {a_mag, 1'b0} + NUM_W'(w_eff);
  assign div_den  = {w_eff, 1'b0};
  assign div_start = (state_q == S_PREP);

  always_comb begin
    n_val = d_q[D_W-1] ? -SNAP_W'(div_quot) : SNAP_W'(div_quot);
    if ((op_q == OP_NEXT) && (BUMP_W'(d_q) > prod_q)) begin
      n_val = n_val + SNAP_W'(1);
    end
    if (n_val < SNAP_W'(-1)) begin
      snapped = CORNER_W'(-1);
    end else if (n_val > SNAP_W'(axis_q ? lim_r : lim_c)) begin
      snapped = axis_q ? lim_r : lim_c;
    end else begin
      snapped = CORNER_W'(n_val);
    end
  end

  assign a_val    = A_W'(p1_q) - A_W'(p2_q);
  assign b_val    = A_W'(p3_q) - A_W'(p4_q);
  assign a_abs    = a_val[A_W-1] ? A_W'(-a_val) : A_W'(a_val);
  assign b_abs    = b_val[A_W-1] ? A_W'(-b_val) : A_W'(b_val);
  assign dcol_abs = dcol_q[HUND_W-1] ? HUND_W'(-dcol_q) : HUND_W'(dcol_q);
  assign drow_abs = drow_q[HUND_W-1] ? HUND_W'(-drow_q) : HUND_W'(drow_q);

  always_comb begin
    col_move = (m1_q <= m2_q);
    mc   = (tc_q < c_q) ? tc_q : c_q;
    mr   = (tr_q < r_q) ? tr_q : r_q;
    row1 = col_move ? r_q : mr;
    col1 = col_move ? mc : c_q;
    row2 = col_move ? (r_q - POS_W'(1)) : mr;
    col2 = col_move ? mc : (c_q - POS_W'(1));
  end

  always_comb begin
    mem_req       = '0;
    mem_req.re    = (in_acc && (in_i.opcode == OP_READ)) || (state_q == S_WR1)
                    || (state_q == S_WR2);
    mem_req.raddr = (state_q == S_WR1) ? addr1_q : ((state_q == S_WR2) ? addr2_q : q_addr);
    mem_req.we    = ((state_q == S_WW1) && ok1_q) || ((state_q == S_WW2) && ok2_q);
    mem_req.waddr = (state_q == S_WW1) ? addr1_q : addr2_q;
    mem_req.wdata = mem_rdata & ~((state_q == S_WW1) ? mask1_q : mask2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      cell_width_q   <= CW_W'(65536);
      used_columns_q <= USED_W'(64);
      used_rows_q    <= USED_W'(64);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ORIGIN_X:     origin_x_q     <= cfg_i.data;
        REG_ORIGIN_Y:     origin_y_q     <= cfg_i.data;
        REG_CELL_WIDTH:   cell_width_q   <= cfg_i.data[CW_W-1:0];
        REG_USED_COLUMNS: used_columns_q <= cfg_i.data[USED_W-1:0];
        REG_USED_ROWS:    used_rows_q    <= cfg_i.data[USED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      corner_col_q <= '0;
      corner_row_q <= '0;
      next_col_q   <= '0;
      next_row_q   <= '0;
      op_q         <= '0;
      px_q         <= '0;
      py_q         <= '0;
      axis_q       <= 1'b0;
      d_q          <= '0;
      prod_q       <= '0;
      c_q          <= '0;
      r_q          <= '0;
      tc_q         <= '0;
      tr_q         <= '0;
      dy_q         <= '0;
      ci_neg_q     <= 1'b0;
      ri_neg_q     <= 1'b0;
      dg_q         <= '0;
      dcol_q       <= '0;
      drow_q       <= '0;
      p1_q         <= '0;
      p2_q         <= '0;
      p3_q         <= '0;
      p4_q         <= '0;
      m1_q         <= '0;
      m2_q         <= '0;
      n_q          <= '0;
      addr1_q      <= '0;
      addr2_q      <= '0;
      ok1_q        <= 1'b0;
      ok2_q        <= 1'b0;
      mask1_q      <= '0;
      mask2_q      <= '0;
      q_oob_q      <= 1'b0;
      res_flags_q  <= '0;
      res_edges_q  <= '0;
      out_valid_q  <= 1'b0;
      out_flags_q  <= '0;
      out_edges_q  <= '0;
    end else begin
      if (out_o.ready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q        <= in_i.opcode;
            px_q        <= in_i.point_x;
            py_q        <= in_i.point_y;
            axis_q      <= 1'b0;
            q_oob_q     <= (int'(in_i.query_row) >= MAX_ROWS)
                           || (int'(in_i.query_col) >= MAX_COLUMNS);
            res_flags_q <= '0;
            res_edges_q <= '0;
            if (in_i.opcode == OP_READ) begin
              state_q <= S_RDQ;
            end else if ((in_i.opcode == OP_START) || (in_i.opcode == OP_NEXT)) begin
              state_q <= S_PREP;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_RDQ: begin
          res_flags_q <= q_oob_q ? FLAGS_OPEN : mem_rdata;
          state_q     <= S_FIN;
        end
        S_PREP: begin
          d_q     <= d_new;
          prod_q  <= BUMP_W'(prev_sel) * BUMP_W'(signed'({1'b0, w_eff}));
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_SNAP;
          end
        end
        S_SNAP: begin
          if (!axis_q) begin
            next_col_q <= snapped;
            axis_q     <= 1'b1;
            state_q    <= S_PREP;
          end else if (op_q == OP_START) begin
            corner_col_q <= next_col_q;
            corner_row_q <= snapped;
            state_q      <= S_FIN;
          end else begin
            next_row_q <= snapped;
            state_q    <= S_WINIT;
          end
        end
        S_WINIT: begin
          c_q      <= POS_W'(corner_col_q);
          r_q      <= POS_W'(corner_row_q);
          dy_q     <= DIFF_W'(nr_pos) - DIFF_W'(corner_row_q);
          ci_neg_q <= (next_col_q < corner_col_q);
          ri_neg_q <= (next_row_q < corner_row_q);
          dg_q     <= hund(DIFF_W'(nc_pos) - DIFF_W'(corner_col_q));
          n_q      <= '0;
          state_q  <= S_WCHK;
        end
        S_WCHK: begin
          if (((c_q != nc_pos) || (r_q != nr_pos)) && (n_q != WALK_LIMIT)) begin
            tc_q    <= ci_neg_q ? (c_q - POS_W'(1)) : (c_q + POS_W'(1));
            tr_q    <= ri_neg_q ? (r_q - POS_W'(1)) : (r_q + POS_W'(1));
            dcol_q  <= hund(DIFF_W'(nc_pos) - DIFF_W'(ci_neg_q ? (c_q - POS_W'(1))
                                                               : (c_q + POS_W'(1))));
            drow_q  <= hund(DIFF_W'(nc_pos) - DIFF_W'(c_q));
            state_q <= S_WM1;
          end else begin
            corner_col_q <= next_col_q;
            corner_row_q <= next_row_q;
            res_edges_q  <= n_q;
            state_q      <= S_FIN;
          end
        end
        S_WM1: begin
          p1_q    <= PROD_W'(DIFF_W'(nr_pos) - DIFF_W'(r_q)) * PROD_W'(dg_q);
          p2_q    <= PROD_W'(dy_q) * PROD_W'(dcol_q);
          p3_q    <= PROD_W'(DIFF_W'(nr_pos) - DIFF_W'(tr_q)) * PROD_W'(dg_q);
          p4_q    <= PROD_W'(dy_q) * PROD_W'(drow_q);
          state_q <= S_WM2;
        end
        S_WM2: begin
          m1_q    <= CMP_W'(a_abs) * CMP_W'(drow_abs);
          m2_q    <= CMP_W'(b_abs) * CMP_W'(dcol_abs);
          state_q <= S_WDEC;
        end
        S_WDEC: begin
          addr1_q <= cell_addr(row1, col1);
          addr2_q <= cell_addr(row2, col2);
          ok1_q   <= in_grid(row1, col1, lim_r, lim_c);
          ok2_q   <= in_grid(row2, col2, lim_r, lim_c);
          mask1_q <= col_move ? FLAG_DOWN : FLAG_LEFT;
          mask2_q <= col_move ? FLAG_UP : FLAG_RIGHT;
          if (col_move) begin
            c_q <= tc_q;
          end else begin
            r_q <= tr_q;
          end
          n_q     <= n_q + EDGE_W'(1);
          state_q <= S_WR1;
        end
        S_WR1: state_q <= S_WW1;
        S_WW1: state_q <= S_WR2;
        S_WR2: state_q <= S_WW2;
        S_WW2: state_q <= S_WCHK;
        S_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_flags_q <= res_flags_q;
            out_edges_q <= res_edges_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.cell_flags   = out_flags_q;
  assign out_o.edges_walked = out_edges_q;

  gebw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  gebw_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (store_busy)
  );

endmodule

// ----- rtl/core/gebw_div.sv -----
module gebw_div import gebw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  assign trial = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= CNT_W'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!diff[DEN_W+1]) begin
          rem_q <= diff[DEN_W:0];
          num_q <= {num_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          num_q <= {num_q[NUM_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ----- rtl/core/gebw_store.sv -----
module gebw_store import gebw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  output logic [FLAG_W-1:0] rdata_o,
  output logic              busy_o
);

  logic [FLAG_W-1:0] mem [DEPTH];
  logic [FLAG_W-1:0] rdata_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              clearing_q;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [FLAG_W-1:0] wdata;

  assign we    = clearing_q | req_i.we;
  assign waddr = clearing_q ? clr_addr_q : req_i.waddr;
  assign wdata = clearing_q ? FLAGS_OPEN : req_i.wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clearing_q;

endmodule

// ----- rtl/core/gebw_checker.sv -----
`include "assert_macros.svh"

module gebw_checker import gebw_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FLAG_W-1:0] cell_flags,
  input logic [EDGE_W-1:0] edges_walked
);

  `GEBW_ASSERT_HOLD(a_out_valid_hold, out_valid, out_ready, out_valid, "result beat dropped")
  `GEBW_ASSERT_HOLD(a_out_data_hold, out_valid, out_ready, {cell_flags, edges_walked}, "result changed while stalled")
  `GEBW_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")
  `GEBW_ASSERT(a_flags_or_edges, (out_valid && (cell_flags != '0)) |-> (edges_walked == '0), "read result reports edges")
  `GEBW_ASSERT(a_clear_after_reset, !$past(rst_ni) |-> !in_ready, "item taken before memory sweep")

endmodule

bind grid_edge_barrier_walker gebw_checker u_gebw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .cell_flags   (out_o.cell_flags),
  .edges_walked (out_o.edges_walked)
);
